>>> rtl/core/ckb_pkg.sv
package ckb_pkg;

	localparam int unsigned PARAM_W = 13;

	localparam logic [9:0] ID_LOW      = 10'd498;
	localparam logic [9:0] ID_HIGH     = 10'd583;
	localparam logic [9:0] ID_FLIP_A   = 10'd498;
	localparam logic [9:0] ID_FLIP_B   = 10'd563;
	localparam logic [9:0] ID_FLIP_C   = 10'd578;
	localparam logic [9:0] ID_FLIP_D   = 10'd580;
	localparam logic [7:0] KEY_COLOR   = 8'd10;

	localparam int unsigned CFG_DATA_W = 11;
	localparam int unsigned CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_GRAPHIC_ID = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_ON  = 3'd7;

	typedef struct packed {
		logic [9:0]         graphic_id;
		logic [8:0]         src_width;
		logic [7:0]         src_height;
		logic signed [10:0] origin_x;
		logic signed [10:0] origin_y;
		logic [9:0]         box_width;
		logic [9:0]         box_height;
		logic               mirror_on;
	} cfg_t;

	typedef struct packed {
		logic        write;
		logic [7:0]  pixel;
		logic [8:0]  column;
		logic [7:0]  row;
		logic [15:0] drawn;
		logic        last;
		logic        rejected;
	} item_t;

endpackage

>>> rtl/core/ckb_track.sv
module ckb_track
	import ckb_pkg::*;
#(
	parameter int unsigned FB_STRIDE = 320,
	parameter int unsigned FB_HEIGHT = 200
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] pixel,
	output logic       item_valid,
	output item_t      item,
	input  logic       item_take
);

	logic [8:0]  column_q;
	logic [7:0]  row_q;
	logic [15:0] drawn_q;
	logic        valid_s1;
	item_t       item_s1;

	logic         accept;
	logic         id_bad, box_bad, org_neg, x_over, y_over, rej;
	logic         empty, end_row, last, wr;
	logic [PARAM_W-1:0] x_end, y_end;
	logic [15:0]  drawn_next;

	assign in_ready = !valid_s1 || item_take;
	assign accept   = in_valid && in_ready;

	// The checks are evaluated per item from the live configuration.
	always_comb begin
		id_bad  = (cfg.graphic_id < ID_LOW) || (cfg.graphic_id > ID_HIGH);
		box_bad = (cfg.box_width < {1'b0, cfg.src_width})
			|| (cfg.box_height < {2'b00, cfg.src_height});
		org_neg = cfg.origin_x[10] || cfg.origin_y[10];
		x_end   = PARAM_W'(cfg.origin_x[10:0]) + PARAM_W'(cfg.src_width);
		y_end   = PARAM_W'(cfg.origin_y[10:0]) + PARAM_W'(cfg.src_height);
		x_over  = x_end > PARAM_W'(FB_STRIDE);
		y_over  = y_end > PARAM_W'(FB_HEIGHT);
		rej     = id_bad || box_bad || org_neg || x_over || y_over;

		empty   = (cfg.src_width == 9'd0) || (cfg.src_height == 8'd0);
		end_row = empty || ({1'b0, column_q} + 10'd1 >= {1'b0, cfg.src_width});
		last    = empty || (end_row && ({1'b0, row_q} + 9'd1 >= {1'b0, cfg.src_height}));
		wr      = !rej && !empty && (pixel != KEY_COLOR);
		drawn_next = drawn_q + 16'(wr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
			drawn_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (last) begin
					column_q <= '0;
					row_q    <= '0;
					drawn_q  <= '0;
				end else if (end_row) begin
					column_q <= '0;
					row_q    <= row_q + 8'd1;
					drawn_q  <= drawn_next;
				end else begin
					column_q <= column_q + 9'd1;
					drawn_q  <= drawn_next;
				end
			end else if (item_take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.write    <= wr;
			item_s1.pixel    <= pixel;
			item_s1.column   <= column_q;
			item_s1.row      <= row_q;
			item_s1.drawn    <= drawn_next;
			item_s1.last     <= last;
			item_s1.rejected <= rej;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

>>> rtl/core/ckb_addr.sv
module ckb_addr
	import ckb_pkg::*;
#(
	parameter int unsigned FB_STRIDE = 320
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        item_valid,
	input  item_t       item,
	output logic        item_take,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        write_valid,
	output logic [15:0] fb_addr,
	output logic [7:0]  write_pixel,
	output logic [15:0] drawn_total,
	output logic        last,
	output logic        rejected
);

	logic        valid_s2;
	logic        write_s2, last_s2, rej_s2;
	logic [15:0] addr_s2, drawn_s2;
	logic [7:0]  pix_s2;

	logic        flip;
	logic [15:0] dx, dy, row_base, addr;

	assign item_take = item_valid && (!valid_s2 || out_ready);

	// Addresses wrap at 16 bits, so all the arithmetic is kept that narrow.
	always_comb begin
		flip = cfg.mirror_on && ((cfg.graphic_id == ID_FLIP_A)
			|| (cfg.graphic_id == ID_FLIP_B) || (cfg.graphic_id == ID_FLIP_C)
			|| (cfg.graphic_id == ID_FLIP_D));
		if (flip) begin
			dx = 16'(cfg.origin_x[10:0]) + 16'(cfg.src_width) - 16'd1
				- 16'(item.column);
		end else begin
			dx = 16'(cfg.origin_x[10:0]) + 16'(item.column);
		end
		dy       = 16'(cfg.origin_y[10:0]) + 16'(item.row);
		row_base = 16'(dy * 16'(FB_STRIDE));
		addr     = row_base + dx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (item_take) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			write_s2 <= item.write;
			addr_s2  <= item.write ? addr : 16'd0;
			pix_s2   <= item.write ? item.pixel : 8'd0;
			drawn_s2 <= item.drawn;
			last_s2  <= item.last;
			rej_s2   <= item.rejected;
		end
	end

	assign out_valid   = valid_s2;
	assign write_valid = write_s2;
	assign fb_addr     = addr_s2;
	assign write_pixel = pix_s2;
	assign drawn_total = drawn_s2;
	assign last        = last_s2;
	assign rejected    = rej_s2;

endmodule

>>> rtl/core/color_key_sprite_blitter_unit.sv
// Color-keyed sprite blitter. Source pixels enter one item per cycle in raster
// order while in_ready is high. Each input item yields one result item that
// moves through both register stages to the outputs. A new item can be taken
// every cycle while out_ready is high (one input register stage, one result
// register stage, short address arithmetic between them). Pixels equal to the
// key color 10 are not written. A result with write_valid set carries the
// framebuffer byte address (origin plus row and column, row times FB_STRIDE,
// modulo 2^16), with the column mirrored when mirror_on is set and the graphic
// id is one of the flippable ids. The blit is rejected, with no writes, if the
// id lies outside 498..583, the box is smaller than the sprite, an origin is
// negative or the sprite overruns the FB_STRIDE by FB_HEIGHT framebuffer.
// After the item flagged last, the position and drawn count return to zero.
// Write the registers only while no items are in flight.
module color_key_sprite_blitter_unit
	import ckb_pkg::*;
#(
	parameter int unsigned FB_STRIDE = 320,
	parameter int unsigned FB_HEIGHT = 200
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            pixel,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  write_valid,
	output logic [15:0]           fb_addr,
	output logic [7:0]            write_pixel,
	output logic [15:0]           drawn_total,
	output logic                  last,
	output logic                  rejected
);

	cfg_t  cfg_q;
	logic  item_valid, item_take;
	item_t item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRAPHIC_ID: cfg_q.graphic_id <= cfg_data[9:0];
				REG_SRC_WIDTH:  cfg_q.src_width  <= cfg_data[8:0];
				REG_SRC_HEIGHT: cfg_q.src_height <= cfg_data[7:0];
				REG_ORIGIN_X:   cfg_q.origin_x   <= cfg_data[10:0];
				REG_ORIGIN_Y:   cfg_q.origin_y   <= cfg_data[10:0];
				REG_BOX_WIDTH:  cfg_q.box_width  <= cfg_data[9:0];
				REG_BOX_HEIGHT: cfg_q.box_height <= cfg_data[9:0];
				REG_MIRROR_ON:  cfg_q.mirror_on  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ckb_track #(
		.FB_STRIDE(FB_STRIDE),
		.FB_HEIGHT(FB_HEIGHT)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel     (pixel),
		.item_valid(item_valid),
		.item      (item),
		.item_take (item_take)
	);

	ckb_addr #(
		.FB_STRIDE(FB_STRIDE)
	) u_addr (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.write_valid(write_valid),
		.fb_addr    (fb_addr),
		.write_pixel(write_pixel),
		.drawn_total(drawn_total),
		.last       (last),
		.rejected   (rejected)
	);

endmodule
